### src/ufc_pkg.sv
// Package for the URL form codec: character constants, the job record passed
// from the front part to the back part, and the byte classification helpers.
// No dependencies.
`default_nettype none

package ufc_pkg;

  // Character codes
  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTilde = 8'h7E;
  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [7:0] CharUscore = 8'h5F;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowZ  = 8'h7A;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] HexBias   = 8'h57;  // 'a' - 10
  localparam logic [3:0] NibTen    = 4'd10;

  // Configuration port
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam logic [0:0]  RegMode  = 1'b0;  // register index of mode

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  // Default job queue depth
  localparam int unsigned QueueDepthDefault = 4;

  typedef enum logic [1:0] {
    PH_TEXT = 2'd0,
    PH_PCT  = 2'd1,
    PH_HELD = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    JOB_MARK = 2'd0,  // end-only marker, no byte
    JOB_ONE  = 2'd1,  // one byte as given
    JOB_ESC  = 2'd2   // '%' and two hex digits of the byte
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [7:0]  data;
    logic        last;
  } job_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CharZero) && (b <= CharNine);
  endfunction

  function automatic logic is_upper(input logic [7:0] b);
    return (b >= CharUpA) && (b <= CharUpZ);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= CharLowA) && (b <= CharLowZ)) || is_upper(b);
  endfunction

  // Letters, digits and - _ . ~ pass through the encoder unchanged
  function automatic logic is_unreserved(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == CharDash) || (b == CharUscore) ||
           (b == CharDot) || (b == CharTilde);
  endfunction

  // Hex value of an escape character, modulo 256
  function automatic logic [7:0] nibble_of(input logic [7:0] b);
    logic [7:0] lower;
    lower = is_upper(b) ? (b + 8'd32) : b;
    return is_digit(b) ? (b - CharZero) : (lower - HexBias);
  endfunction

  // Lowercase hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    return (n < NibTen) ? (CharZero + {4'b0, n}) : (HexBias + {4'b0, n});
  endfunction

endpackage

`default_nettype wire

### src/url_form_codec_unit.sv
// URL form codec, top level: configuration register, front part, job queue
// and back part. Depends on ufc_pkg, ufc_front, ufc_job_queue, ufc_back.
//
// Usage: string bytes enter through a queue-style port (push/full), one byte
// per item with is_last_i on the final byte. Converted bytes leave through a
// queue-style port (empty/pop); has_byte_o low marks an end-only result.
// Register mode (byte address 0) selects encoding (0) or decoding (1); a
// write clears the decode escape state and should only be made while idle.
// An accepted item is written into the job queue and then loaded into the
// back part's result stage. Throughput: one result byte per cycle while the
// receiver keeps popping, set by the back part's single output stage; an
// escaped byte in encode mode gives three result bytes, any other job one
// result. Inputs are taken every cycle while the job queue (QueueDepth
// entries) has room, also while a result waits to be popped.
// Reset: mode returns to encode, queue and result stage empty, escape state
// cleared. When the receiver stalls, the result holds and the queue fills
// until full is raised.
`default_nettype none

module url_form_codec_unit #(
  parameter int unsigned QueueDepth = ufc_pkg::QueueDepthDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ufc_pkg::ApbAddrW-1:0]   paddr,
  input  wire logic [ufc_pkg::ApbDataW-1:0]   pwdata,
  output logic      [ufc_pkg::ApbDataW-1:0]   prdata,
  output logic                                pready,
  // input items
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [7:0]                     in_byte_i,
  input  wire logic                           is_last_i,
  // results
  output logic                                empty,
  input  wire logic                           pop,
  output logic [7:0]                          out_byte_o,
  output logic                                has_byte_o,
  output logic                                end_of_string_o
);
  import ufc_pkg::*;

  logic  mode_q;
  logic  mode_wr;
  logic  accept;
  logic  job_valid;
  job_t  job_in, job_out;
  logic  q_empty, q_pop;

  // Mode register
  assign pready  = 1'b1;
  assign mode_wr = psel && penable && pwrite && (paddr[ApbAddrW-1:2] == RegMode);
  assign prdata  = (paddr[ApbAddrW-1:2] == RegMode) ? {{(ApbDataW-1){1'b0}}, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeEncode;
    end else if (mode_wr) begin
      mode_q <= pwdata[0];
    end
  end

  assign accept = push && !full;

  ufc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .clear_i     (mode_wr),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .is_last_i   (is_last_i),
    .job_valid_o (job_valid),
    .job_o       (job_in)
  );

  ufc_job_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && job_valid),
    .data_i  (job_in),
    .pop_i   (q_pop),
    .data_o  (job_out),
    .full_o  (full),
    .empty_o (q_empty)
  );

  ufc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (!q_empty),
    .job_i           (job_out),
    .job_pop_o       (q_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .out_byte_o      (out_byte_o),
    .has_byte_o      (has_byte_o),
    .end_of_string_o (end_of_string_o)
  );

endmodule

`default_nettype wire

### src/ufc_front.sv
// Front part of the URL form codec: accepts items, tracks the decode escape
// state and turns each item into at most one job. Depends on ufc_pkg.
`default_nettype none

module ufc_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        mode_i,
  input  wire logic        clear_i,
  input  wire logic        accept_i,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        is_last_i,
  output logic             job_valid_o,
  output ufc_pkg::job_t    job_o
);
  import ufc_pkg::*;

  phase_e     phase_q, phase_d;
  logic [3:0] held_nib_q, held_nib_d;
  logic [7:0] in_nib;

  // Hex value of the incoming byte
  assign in_nib = nibble_of(in_byte_i);

  // Classify the item into a job
  always_comb begin
    job_valid_o = 1'b0;
    job_o.kind  = JOB_ONE;
    job_o.data  = in_byte_i;
    job_o.last  = is_last_i;
    if (mode_i == ModeEncode) begin
      job_valid_o = 1'b1;
      if (is_unreserved(in_byte_i)) begin
        job_o.kind = JOB_ONE;
      end else if (in_byte_i == CharSpace) begin
        job_o.data = CharPlus;
      end else begin
        job_o.kind = JOB_ESC;
      end
    end else begin
      unique case (phase_q)
        PH_PCT: begin
          // escape cut short: drop the '%', treat the byte as plain text
          if (is_last_i) begin
            if (in_byte_i == CharPlus) begin
              job_valid_o = 1'b1;
              job_o.data  = CharSpace;
            end else if (in_byte_i != CharPct) begin
              job_valid_o = 1'b1;
            end
          end
        end
        PH_HELD: begin
          job_valid_o = 1'b1;
          job_o.data  = {held_nib_q, 4'b0} | in_nib;
        end
        default: begin
          if (in_byte_i == CharPlus) begin
            job_valid_o = 1'b1;
            job_o.data  = CharSpace;
          end else if (in_byte_i != CharPct) begin
            job_valid_o = 1'b1;
          end
        end
      endcase
    end
    // final item without a byte gives an end marker
    if (is_last_i && !job_valid_o) begin
      job_valid_o = 1'b1;
      job_o.kind  = JOB_MARK;
      job_o.data  = 8'h00;
    end
  end

  // Next escape phase
  always_comb begin
    phase_d    = phase_q;
    held_nib_d = held_nib_q;
    if (clear_i) begin
      phase_d    = PH_TEXT;
      held_nib_d = 4'h0;
    end else if (accept_i) begin
      if (mode_i == ModeDecode) begin
        unique case (phase_q)
          PH_PCT: begin
            phase_d    = PH_HELD;
            held_nib_d = in_nib[3:0];
          end
          PH_HELD: begin
            phase_d = PH_TEXT;
          end
          default: begin
            phase_d = (in_byte_i == CharPct) ? PH_PCT : PH_TEXT;
          end
        endcase
      end
      if (is_last_i) begin
        phase_d    = PH_TEXT;
        held_nib_d = 4'h0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_TEXT;
      held_nib_q <= 4'h0;
    end else begin
      phase_q    <= phase_d;
      held_nib_q <= held_nib_d;
    end
  end

endmodule

`default_nettype wire

### src/ufc_job_queue.sv
// Short job queue between the front and back parts of the URL form codec.
// Depends on ufc_pkg for the job record.
`default_nettype none

module ufc_job_queue #(
  parameter int unsigned Depth = ufc_pkg::QueueDepthDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ufc_pkg::job_t data_i,
  input  wire logic          pop_i,
  output ufc_pkg::job_t      data_o,
  output logic               full_o,
  output logic               empty_o
);
  import ufc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slots_q[rd_ptr_q];

  // Store jobs
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/ufc_back.sv
// Back part of the URL form codec: carries out jobs one byte per cycle
// when not stalled, into a registered result stage. Depends on ufc_pkg.
`default_nettype none

module ufc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  wire ufc_pkg::job_t job_i,
  output logic               job_pop_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output logic [7:0]         out_byte_o,
  output logic               has_byte_o,
  output logic               end_of_string_o
);
  import ufc_pkg::*;

  logic       out_valid_q;
  logic [7:0] byte_q, byte_d;
  logic       has_q, has_d;
  logic       end_q, end_d;
  logic [1:0] step_q;
  logic       final_step;
  logic       advance, load;

  assign advance   = !out_valid_q || pop_i;
  assign load      = advance && job_valid_i;
  assign job_pop_o = load && final_step;

  // Pick the byte for the current step of the job
  always_comb begin
    byte_d     = job_i.data;
    has_d      = 1'b1;
    final_step = 1'b1;
    unique case (job_i.kind)
      JOB_MARK: begin
        byte_d = 8'h00;
        has_d  = 1'b0;
      end
      JOB_ESC: begin
        final_step = (step_q == 2'd2);
        if (step_q == 2'd0) begin
          byte_d = CharPct;
        end else if (step_q == 2'd1) begin
          byte_d = hex_digit(job_i.data[7:4]);
        end else begin
          byte_d = hex_digit(job_i.data[3:0]);
        end
      end
      default: begin
        byte_d = job_i.data;
      end
    endcase
    end_d = job_i.last && final_step;
  end

  // Result stage payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      has_q  <= has_d;
      end_q  <= end_d;
    end
  end

  // Result stage valid and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= 2'd0;
    end else begin
      if (advance) begin
        out_valid_q <= job_valid_i;
      end
      if (load) begin
        step_q <= final_step ? 2'd0 : step_q + 2'd1;
      end
    end
  end

  assign empty_o         = !out_valid_q;
  assign out_byte_o      = byte_q;
  assign has_byte_o      = has_q;
  assign end_of_string_o = end_q;

endmodule

`default_nettype wire

### src/ufc_checker.sv
// Port-level checks for the URL form codec, bound to url_form_codec_unit.
// Depends on nothing but the top level's ports.
`default_nettype none

module ufc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte_o,
  input wire logic       has_byte_o,
  input wire logic       end_of_string_o
);

  // An end-only result carries no byte and closes the string
  a_marker_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !has_byte_o) |-> (end_of_string_o && (out_byte_o == 8'h00)))
    else $error("end marker without end_of_string or with a byte");

  // A full job queue feeds the result stage on the next cycle
  a_full_feeds_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full && empty) |=> !empty)
    else $error("result stage stays empty while the queue is full");

  // A stalled result holds
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(has_byte_o) &&
                          $stable(end_of_string_o)))
    else $error("stalled result changed or vanished");

endmodule

bind url_form_codec_unit ufc_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .out_byte_o      (out_byte_o),
  .has_byte_o      (has_byte_o),
  .end_of_string_o (end_of_string_o)
);

`default_nettype wire

### dv/tb_url_form_codec_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for url_form_codec_unit: directed and random strings in
// both codec modes, checked result by result against a predictor kept here.
// Depends on ufc_pkg and the url_form_codec_unit RTL.

module tb_url_form_codec_unit;
  import ufc_pkg::*;

  localparam int unsigned RegModeIdx   = int'(RegMode);
  localparam int unsigned RegUnused    = 1;          // index with no register behind it
  localparam int unsigned SettleCycles = 12;         // cover the queue and output stages
  localparam int unsigned TimeoutNs    = 2_000_000;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       eos;
  } codec_out_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                push;
  logic                full;
  logic [7:0]          in_byte_i;
  logic                is_last_i;
  logic                empty;
  logic                pop;
  logic [7:0]          out_byte_o;
  logic                has_byte_o;
  logic                end_of_string_o;

  // Predictor state
  logic       codec_mode;
  phase_e     dec_phase;
  logic [7:0] dec_held;
  codec_out_t pending_results[$];

  logic [7:0] str_q[$];
  int         burst_left;
  int         errors;
  int         rx_cycle;
  int         rx_style;

  url_form_codec_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .push            (push),
    .full            (full),
    .in_byte_i       (in_byte_i),
    .is_last_i       (is_last_i),
    .empty           (empty),
    .pop             (pop),
    .out_byte_o      (out_byte_o),
    .has_byte_o      (has_byte_o),
    .end_of_string_o (end_of_string_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(TimeoutNs);
    $display("tb_url_form_codec_unit failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] hex_char_of(input logic [3:0] n);
    if (n <= 4'd9) begin
      return CharZero + {4'h0, n};
    end
    return CharLowA + {4'h0, n} - 8'd10;
  endfunction

  // Value of an escape character, wrapping for anything that is not hex
  function automatic logic [7:0] escape_value(input logic [7:0] c);
    logic [7:0] folded;
    folded = (c >= CharUpA && c <= CharUpZ) ? c + 8'd32 : c;
    if (c >= CharZero && c <= CharNine) begin
      return c - CharZero;
    end
    return folded - HexBias;
  endfunction

  function automatic logic passes_unchanged(input logic [7:0] c);
    return (c >= CharLowA && c <= CharLowZ) || (c >= CharUpA && c <= CharUpZ) ||
           (c >= CharZero && c <= CharNine) || c == CharDash || c == CharUscore ||
           c == CharDot || c == CharTilde;
  endfunction

  function automatic void predict_codec_item(input logic [7:0] b, input logic last);
    logic [7:0] outs[3];
    logic [7:0] hi;
    int         n;
    n = 0;
    if (codec_mode == ModeEncode) begin
      if (passes_unchanged(b)) begin
        outs[0] = b;
        n = 1;
      end else if (b == CharSpace) begin
        outs[0] = CharPlus;
        n = 1;
      end else begin
        outs[0] = CharPct;
        outs[1] = hex_char_of(b[7:4]);
        outs[2] = hex_char_of(b[3:0]);
        n = 3;
      end
    end else begin
      case (dec_phase)
        PH_PCT: begin
          if (last) begin
            // escape cut short: drop the '%' and treat the byte as text
            if (b == CharPlus) begin
              outs[0] = CharSpace;
              n = 1;
            end else if (b != CharPct) begin
              outs[0] = b;
              n = 1;
            end
            dec_phase = PH_TEXT;
          end else begin
            dec_held  = b;
            dec_phase = PH_HELD;
          end
        end
        PH_HELD: begin
          hi        = escape_value(dec_held);
          outs[0]   = {hi[3:0], 4'h0} | escape_value(b);
          n         = 1;
          dec_phase = PH_TEXT;
          dec_held  = 8'h00;
        end
        default: begin
          dec_phase = PH_TEXT;
          if (b == CharPct) begin
            if (!last) begin
              dec_phase = PH_PCT;
            end
          end else if (b == CharPlus) begin
            outs[0] = CharSpace;
            n = 1;
          end else begin
            outs[0] = b;
            n = 1;
          end
        end
      endcase
    end
    // a string that ends without a byte still closes with a marker
    if (last && n == 0) begin
      pending_results.push_back('{data: 8'h00, has: 1'b0, eos: 1'b1});
    end
    for (int k = 0; k < n; k++) begin
      pending_results.push_back('{data: outs[k], has: 1'b1, eos: last && (k == n - 1)});
    end
    if (last) begin
      dec_phase = PH_TEXT;
      dec_held  = 8'h00;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checker
  // ---------------------------------------------------------------------------

  // Drive pop in one of four stall styles, picked anew at random
  always @(negedge clk_i) begin
    if (rx_cycle % 48 == 0) begin
      rx_style = $urandom_range(0, 3);
    end
    rx_cycle++;
    case (rx_style)
      0:       pop <= 1'b1;
      1:       pop <= 1'($urandom_range(0, 1));
      2:       pop <= ($urandom_range(0, 4) == 0);
      default: pop <= ((rx_cycle / 4) % 2 == 0);
    endcase
  end

  always @(posedge clk_i) begin : check_results
    codec_out_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result byte", out_byte_o, 8'h00);
      end else begin
        want = pending_results.pop_front();
        if (out_byte_o !== want.data) begin
          report_mismatch("out_byte", out_byte_o, want.data);
        end
        if (has_byte_o !== want.has) begin
          report_mismatch("has_byte", {7'h0, has_byte_o}, {7'h0, want.has});
        end
        if (end_of_string_o !== want.eos) begin
          report_mismatch("end_of_string", {7'h0, end_of_string_o}, {7'h0, want.eos});
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side and register access
  // ---------------------------------------------------------------------------

  // Send one item; bursts of random length with random gaps between them
  task automatic send_item(input logic [7:0] b, input logic last);
    if (burst_left == 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) :
                                                 $urandom_range(1, 6);
    end
    @(negedge clk_i);
    push      <= 1'b1;
    in_byte_i <= b;
    is_last_i <= last;
    do @(posedge clk_i); while (full);
    predict_codec_item(b, last);
    burst_left--;
  endtask

  task automatic send_text();
    for (int k = 0; k < str_q.size(); k++) begin
      send_item(str_q[k], k == str_q.size() - 1);
    end
  endtask

  // Hold the sender until every expected result is out, then let the pipe settle
  task automatic wait_drained();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic reg_access(input logic wr, input int unsigned idx,
                            input logic [ApbDataW-1:0] wdata,
                            input logic [ApbDataW-1:0] rwant);
    logic [ApbAddrW-1:0] addr;
    addr = ApbAddrW'(idx * 4);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (!wr && prdata !== rwant) begin
      report_mismatch("mode register read", prdata[7:0], rwant[7:0]);
    end
    if (wr && idx == RegModeIdx) begin
      codec_mode = wdata[0];
      dec_phase  = PH_TEXT;
      dec_held   = 8'h00;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_mode(input logic m);
    wait_drained();
    reg_access(1'b1, RegModeIdx, {31'h0, m}, '0);
    reg_access(1'b0, RegModeIdx, '0, {31'h0, m});
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_register_reset();
    reg_access(1'b0, RegModeIdx, '0, {31'h0, ModeEncode});
  endtask

  task automatic test_encode_directed();
    write_mode(ModeEncode);
    str_q = '{CharLowA, CharUpZ, CharZero, CharNine, CharTilde, CharSpace,
              8'h2F, 8'h01, 8'h80, 8'hFF};
    send_text();
  endtask

  // A write to an empty slot must leave mode alone
  task automatic test_unused_register();
    wait_drained();
    reg_access(1'b1, RegUnused, 32'h1, '0);
    reg_access(1'b0, RegModeIdx, '0, {31'h0, codec_mode});
    str_q = '{CharSpace};
    send_text();
  endtask

  task automatic test_decode_directed();
    write_mode(ModeDecode);
    // plus, valid escapes, non-hex escape, decoded zero ending the string
    str_q = '{CharPlus, CharPct, 8'h34, 8'h31, CharPct, 8'h46, 8'h67,
              CharPct, CharZero, CharZero};
    send_text();
    // lone '%': nothing to emit, marker only
    str_q = '{CharPct};
    send_text();
    // escape cut after one byte
    str_q = '{CharPct, CharPlus};
    send_text();
    str_q = '{CharPct, CharPct};
    send_text();
  endtask

  // Park the decoder mid-escape, then rewrite mode: the escape must be forgotten
  task automatic test_mode_write_clears();
    write_mode(ModeDecode);
    str_q = '{CharPct, 8'h34};
    foreach (str_q[k]) send_item(str_q[k], 1'b0);
    write_mode(ModeDecode);
    str_q = '{8'h31};
    send_text();
  endtask

  task automatic test_random_encode(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    write_mode(ModeEncode);
    sent = 0;
    while (sent < n_items) begin
      len   = $urandom_range(1, 8);
      str_q = {};
      repeat (len) begin
        case ($urandom_range(0, 3))
          0:       str_q.push_back(CharSpace);
          1:       str_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
          default: str_q.push_back(8'($urandom_range(1, 255)));
        endcase
      end
      send_text();
      sent += len;
    end
  endtask

  function automatic logic [7:0] random_hex_char();
    case ($urandom_range(0, 2))
      0:       return CharZero + 8'($urandom_range(0, 9));
      1:       return CharLowA + 8'($urandom_range(0, 5));
      default: return CharUpA + 8'($urandom_range(0, 5));
    endcase
  endfunction

  // Mostly well-formed escapes with random content; some strings cut mid-escape
  task automatic test_random_decode(input int unsigned n_items, input logic hold_off);
    int unsigned sent;
    int unsigned len;
    int unsigned cut;
    write_mode(ModeDecode);
    sent = 0;
    while (sent < n_items) begin
      len   = $urandom_range(1, 6);
      str_q = {};
      repeat (len) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: str_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
          4:          str_q.push_back(CharPlus);
          9:          str_q.push_back(8'($urandom_range(1, 255)));
          default: begin
            str_q.push_back(CharPct);
            str_q.push_back(random_hex_char());
            str_q.push_back(random_hex_char());
          end
        endcase
      end
      if ($urandom_range(0, 2) == 0) begin
        cut = $urandom_range(1, str_q.size());
        while (str_q.size() > cut) void'(str_q.pop_back());
      end
      send_text();
      sent += str_q.size();
      // one full stop of the sender until the results have all come out
      if (hold_off && sent >= n_items / 2) begin
        wait_drained();
        hold_off = 1'b0;
      end
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    push       = 1'b0;
    in_byte_i  = 8'h00;
    is_last_i  = 1'b0;
    pop        = 1'b0;
    codec_mode = ModeEncode;
    dec_phase  = PH_TEXT;
    dec_held   = 8'h00;
    burst_left = 0;
    errors     = 0;
    rx_cycle   = 0;
    rx_style   = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_register_reset();
    test_encode_directed();
    test_unused_register();
    test_decode_directed();
    test_mode_write_clears();
    test_random_encode(22);
    test_random_decode(22, 1'b1);
    test_random_encode(22);
    test_random_decode(22, 1'b0);

    wait_drained();
    if (errors == 0) begin
      $display("tb_url_form_codec_unit passed");
    end else begin
      $display("tb_url_form_codec_unit failed");
    end
    $finish;
  end

endmodule
